// ===== rtl/qalu_pkg.sv =====
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared types and default sizes of the quaternion ALU.
// ----------------------------------------------------------------------------
package qalu_pkg;

    localparam int DEF_VALUE_WIDTH   = 32;
    localparam int DEF_FRACTION_BITS = 16;

    typedef enum logic [1:0] {
        MODE_QMUL = 2'd0,
        MODE_VMUL = 2'd1,
        MODE_CONJ = 2'd2,
        MODE_NORM = 2'd3
    } t_mode;

endpackage

// ===== rtl/qalu_if.sv =====
// ----------------------------------------------------------------------------
// qalu_if
// Operand and result channels of the quaternion ALU (valid/ready).
// ----------------------------------------------------------------------------
interface qalu_in_if #(
    parameter int VW = qalu_pkg::DEF_VALUE_WIDTH
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           mode;
    logic signed [VW-1:0] a_x;
    logic signed [VW-1:0] a_y;
    logic signed [VW-1:0] a_z;
    logic signed [VW-1:0] a_w;
    logic signed [VW-1:0] b_x;
    logic signed [VW-1:0] b_y;
    logic signed [VW-1:0] b_z;
    logic signed [VW-1:0] b_w;

    modport source (output valid, mode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                    input ready);
    modport sink   (input valid, mode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                    output ready);
endinterface

interface qalu_out_if #(
    parameter int VW = qalu_pkg::DEF_VALUE_WIDTH
);
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] r_x;
    logic signed [VW-1:0] r_y;
    logic signed [VW-1:0] r_z;
    logic signed [VW-1:0] r_w;
    logic                 zero_length;

    modport source (output valid, r_x, r_y, r_z, r_w, zero_length, input ready);
    modport sink   (input valid, r_x, r_y, r_z, r_w, zero_length, output ready);
endinterface

// ===== rtl/quaternion_alu_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_alu_unit
// Hamilton product, vector product, conjugate and normalize on Q fixed point.
// ----------------------------------------------------------------------------
// Every mode takes the same path: operand capture, products, sums, the
// bit-per-stage square root and divider pipelines, then the output register.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register waits.
// Reset: synchronous active-low i_rst_n clears all valid bits.
module quaternion_alu_unit #(
    parameter int VALUE_WIDTH   = qalu_pkg::DEF_VALUE_WIDTH,
    parameter int FRACTION_BITS = qalu_pkg::DEF_FRACTION_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    qalu_in_if.sink  i_in,
    qalu_out_if.source o_out
);
    import qalu_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int PW = 2 * VW;
    localparam int CW = 2 * VW + 2;
    localparam int SW = CW;
    localparam int LW = VW + 1;
    localparam int NW = VW + FB;

    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    typedef logic [3:0][VW-1:0] t_vec;

    typedef struct packed {
        t_mode          mode;
        t_vec           res;
        logic [3:0]     neg;
        t_vec           mag;
        logic [SW-1:0]  src;
        logic [LW:0]    rem;
        logic [LW-1:0]  root;
    } t_sq;

    typedef struct packed {
        t_mode               mode;
        t_vec                res;
        logic [3:0]          neg;
        logic [3:0][NW-1:0]  num;
        logic [3:0][LW-1:0]  rem;
        logic [3:0][NW-1:0]  quo;
        logic [LW-1:0]       len;
    } t_dv;

    function automatic logic signed [CW-1:0] ext(input logic signed [PW-1:0] p);
        ext = {{(CW-PW){p[PW-1]}}, p};
    endfunction

    function automatic logic [VW-1:0] sat_c(input logic signed [CW-1:0] c);
        logic signed [CW-1:0] s;
        s = c >>> FB;
        if (&s[CW-1:VW-1] || ~|s[CW-1:VW-1]) begin
            sat_c = s[VW-1:0];
        end else begin
            sat_c = s[CW-1] ? VMIN : VMAX;
        end
    endfunction

    function automatic logic [VW-1:0] neg_sat(input logic [VW-1:0] a);
        neg_sat = (a == VMIN) ? VMAX : (~a + 1'b1);
    endfunction

    function automatic logic [VW-1:0] sat_q(input logic [NW-1:0] q, input logic neg);
        logic [NW:0] s;
        s = neg ? (~{1'b0, q} + 1'b1) : {1'b0, q};
        if (&s[NW:VW-1] || ~|s[NW:VW-1]) begin
            sat_q = s[VW-1:0];
        end else begin
            sat_q = s[NW] ? VMIN : VMAX;
        end
    endfunction

    logic en;
    logic r_out_v;
    assign en         = !r_out_v || o_out.ready;
    assign i_in.ready = en;

    // ---------------- stage 1: operand capture ----------------
    logic  r1_v;
    t_mode r1_mode;
    t_vec  r1_a, r1_b;
    t_mode n1_mode;
    t_vec  n1_a, n1_b;

    always_comb begin
        n1_mode = t_mode'(i_in.mode);
        n1_a    = {i_in.a_w, i_in.a_z, i_in.a_y, i_in.a_x};
        n1_b    = {i_in.b_w, i_in.b_z, i_in.b_y, i_in.b_x};
        // squares for the length come out of the same multipliers
        if (n1_mode == MODE_NORM) begin
            n1_b = n1_a;
        end else if (n1_mode == MODE_VMUL) begin
            n1_b[3] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
        end
        if (en) begin
            r1_mode <= n1_mode;
            r1_a    <= n1_a;
            r1_b    <= n1_b;
        end
    end

    // ---------------- stage 2: sixteen products ----------------
    logic                 r2_v;
    t_mode                r2_mode;
    t_vec                 r2_a;
    logic signed [PW-1:0] r2_p [4][4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_mode <= r1_mode;
            r2_a    <= r1_a;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r2_p[i][j] <= $signed(r1_a[i]) * $signed(r1_b[j]);
                end
            end
        end
    end

    // ---------------- stage 3: component sums ----------------
    logic                 r3_v;
    t_mode                r3_mode;
    t_vec                 r3_a;
    logic signed [CW-1:0] r3_c [4];
    logic [SW-1:0]        r3_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
        if (en) begin
            r3_mode <= r2_mode;
            r3_a    <= r2_a;
            r3_c[0] <= ext(r2_p[0][3]) + ext(r2_p[3][0]) + ext(r2_p[1][2]) - ext(r2_p[2][1]);
            r3_c[1] <= ext(r2_p[1][3]) + ext(r2_p[3][1]) + ext(r2_p[2][0]) - ext(r2_p[0][2]);
            r3_c[2] <= ext(r2_p[2][3]) + ext(r2_p[3][2]) + ext(r2_p[0][1]) - ext(r2_p[1][0]);
            r3_c[3] <= ext(r2_p[3][3]) - ext(r2_p[0][0]) - ext(r2_p[1][1]) - ext(r2_p[2][2]);
            r3_sq   <= ext(r2_p[0][0]) + ext(r2_p[1][1]) + ext(r2_p[2][2]) + ext(r2_p[3][3]);
        end
    end

    // ---------------- stage 4: finish non-normalize, seed square root ----------------
    t_sq  r_sq   [0:LW];
    logic r_sq_v [0:LW];
    t_sq  n_sq0;

    always_comb begin
        n_sq0.mode = r3_mode;
        n_sq0.src  = r3_sq;
        n_sq0.rem  = '0;
        n_sq0.root = '0;
        for (int i = 0; i < 4; i++) begin
            n_sq0.neg[i] = r3_a[i][VW-1];
            n_sq0.mag[i] = r3_a[i][VW-1] ? (~r3_a[i] + 1'b1) : r3_a[i];
            case (r3_mode)
                MODE_QMUL, MODE_VMUL: n_sq0.res[i] = sat_c(r3_c[i]);
                MODE_CONJ:            n_sq0.res[i] = (i == 3) ? r3_a[i] : neg_sat(r3_a[i]);
                default:              n_sq0.res[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r_sq_v[0] <= r3_v;
        end
        if (en) begin
            r_sq[0] <= n_sq0;
        end
    end

    // ---------------- square root: one root bit per stage ----------------
    for (genvar k = 1; k <= LW; k++) begin : g_sqrt
        t_sq            n_sq;
        logic [LW+2:0]  rs, tr;

        always_comb begin
            n_sq     = r_sq[k-1];
            rs       = {r_sq[k-1].rem, r_sq[k-1].src[SW-1 -: 2]};
            tr       = {1'b0, r_sq[k-1].root, 2'b01};
            n_sq.src = r_sq[k-1].src << 2;
            if (rs >= tr) begin
                n_sq.rem  = (LW+1)'(rs - tr);
                n_sq.root = {r_sq[k-1].root[LW-2:0], 1'b1};
            end else begin
                n_sq.rem  = rs[LW:0];
                n_sq.root = {r_sq[k-1].root[LW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (en) begin
                r_sq_v[k] <= r_sq_v[k-1];
            end
            if (en) begin
                r_sq[k] <= n_sq;
            end
        end
    end

    // ---------------- divider seed ----------------
    t_dv  r_dv   [0:NW];
    logic r_dv_v [0:NW];
    t_dv  n_dv0;

    always_comb begin
        n_dv0.mode = r_sq[LW].mode;
        n_dv0.res  = r_sq[LW].res;
        n_dv0.neg  = r_sq[LW].neg;
        n_dv0.len  = r_sq[LW].root;
        n_dv0.rem  = '0;
        n_dv0.quo  = '0;
        for (int i = 0; i < 4; i++) begin
            n_dv0.num[i] = {r_sq[LW].mag[i], {FB{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_sq_v[LW];
        end
        if (en) begin
            r_dv[0] <= n_dv0;
        end
    end

    // ---------------- restoring divide: one quotient bit per stage ----------------
    for (genvar j = 1; j <= NW; j++) begin : g_div
        t_dv          n_dv;
        logic [LW:0]  rs [4];

        always_comb begin
            n_dv = r_dv[j-1];
            for (int i = 0; i < 4; i++) begin
                rs[i]       = {r_dv[j-1].rem[i], r_dv[j-1].num[i][NW-1]};
                n_dv.num[i] = r_dv[j-1].num[i] << 1;
                if (rs[i] >= {1'b0, r_dv[j-1].len}) begin
                    n_dv.rem[i] = LW'(rs[i] - {1'b0, r_dv[j-1].len});
                    n_dv.quo[i] = {r_dv[j-1].quo[i][NW-2:0], 1'b1};
                end else begin
                    n_dv.rem[i] = rs[i][LW-1:0];
                    n_dv.quo[i] = {r_dv[j-1].quo[i][NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (en) begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
            if (en) begin
                r_dv[j] <= n_dv;
            end
        end
    end

    // ---------------- output register ----------------
    t_vec  r_out_res, n_out_res;
    logic  r_out_zero, n_out_zero;
    t_mode r_out_mode;

    always_comb begin
        n_out_res  = r_dv[NW].res;
        n_out_zero = 1'b0;
        if (r_dv[NW].mode == MODE_NORM) begin
            if (r_dv[NW].len == '0) begin
                n_out_res  = '0;
                n_out_zero = 1'b1;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    n_out_res[i] = sat_q(r_dv[NW].quo[i], r_dv[NW].neg[i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv_v[NW];
        end
        if (en) begin
            r_out_res  <= n_out_res;
            r_out_zero <= n_out_zero;
            r_out_mode <= r_dv[NW].mode;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.r_x         = r_out_res[0];
    assign o_out.r_y         = r_out_res[1];
    assign o_out.r_z         = r_out_res[2];
    assign o_out.r_w         = r_out_res[3];
    assign o_out.zero_length = r_out_zero;

`ifndef SYNTH
    a_zero_gives_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zero_length |->
            o_out.r_x == '0 && o_out.r_y == '0 && o_out.r_z == '0 && o_out.r_w == '0)
        else $error("zero length result carries nonzero components");

    a_flag_only_normalize: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zero_length |-> r_out_mode == MODE_NORM)
        else $error("zero length flag outside normalize");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

    a_stall_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_dv_v[NW]) && $stable(r_out_res))
        else $error("pipeline moved during stall");
`endif

endmodule

// ===== sim/tb_quaternion_alu_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_alu_unit
// Drives operand transfers with random gaps into the quaternion ALU and checks
// every result transfer, in order, against typed-in results or a predictor of all four modes.
// ----------------------------------------------------------------------------
module tb_quaternion_alu_unit;
    import qalu_pkg::*;

    localparam int VW = 32;
    localparam int FB = 16;
    localparam int N_RANDOM = 1600;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        t_mode              mode;
        logic signed [VW-1:0] a [4];
        logic signed [VW-1:0] b [4];
    } t_op;

    typedef struct {
        logic signed [VW-1:0] r [4];
        logic                 zl;
    } t_res;

    typedef struct {
        t_op  op;
        bit   has_exp;
        t_res exp_res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    qalu_in_if  #(.VW(VW)) in_ch ();
    qalu_out_if #(.VW(VW)) out_ch ();

    quaternion_alu_unit #(.VALUE_WIDTH(VW), .FRACTION_BITS(FB)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_res result_queue [$];
    int   n_errors = 0;
    int   idle_cycles = 0;
    int   stall_left = 0;
    bit   stim_done = 0;

    function automatic logic signed [VW-1:0] sat_wide(logic signed [199:0] v);
        logic signed [199:0] hi;
        logic signed [199:0] lo;
        hi = (200'sd1 <<< (VW - 1)) - 1;
        lo = -(200'sd1 <<< (VW - 1));
        if (v > hi) return hi[VW-1:0];
        if (v < lo) return lo[VW-1:0];
        return v[VW-1:0];
    endfunction

    function automatic logic [127:0] isqrt(logic [127:0] v);
        logic [127:0] res;
        logic [127:0] bitv;
        res = '0;
        bitv = 128'd1 << 126;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_res quat_predict(t_op op);
        t_res o;
        logic signed [199:0] ax, ay, az, aw, bx, by, bz, bw, acc [4];
        logic [127:0] sum, len, num, q;
        ax = op.a[0]; ay = op.a[1]; az = op.a[2]; aw = op.a[3];
        bx = op.b[0]; by = op.b[1]; bz = op.b[2];
        bw = (op.mode == MODE_VMUL) ? 200'sd0 : 200'(op.b[3]);
        o.zl = 1'b0;
        case (op.mode)
            MODE_QMUL, MODE_VMUL: begin
                acc[3] = aw*bw - ax*bx - ay*by - az*bz;
                acc[0] = ax*bw + aw*bx + ay*bz - az*by;
                acc[1] = ay*bw + aw*by + az*bx - ax*bz;
                acc[2] = az*bw + aw*bz + ax*by - ay*bx;
                for (int i = 0; i < 4; i++) o.r[i] = sat_wide(acc[i] >>> FB);
            end
            MODE_CONJ: begin
                for (int i = 0; i < 3; i++) o.r[i] = sat_wide(-200'(op.a[i]));
                o.r[3] = op.a[3];
            end
            default: begin
                sum = 128'(ax*ax) + 128'(ay*ay) + 128'(az*az) + 128'(aw*aw);
                len = isqrt(sum);
                if (len == 0) begin
                    for (int i = 0; i < 4; i++) o.r[i] = '0;
                    o.zl = 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        acc[i] = op.a[i];
                        num = 128'((acc[i] < 0) ? -acc[i] : acc[i]) << FB;
                        q = num / len;
                        acc[i] = (op.a[i] < 0) ? -200'(q) : 200'(q);
                        o.r[i] = sat_wide(acc[i]);
                    end
                end
            end
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [VW-1:0] got, logic [VW-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic logic signed [VW-1:0] rand_val();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return 32'(int'($urandom_range(0, 8'hff)) - 128) <<< 16;
            4: return 32'($urandom_range(0, 3'h7)) - 3;
            5, 6: return 32'(int'($urandom_range(0, 20'hfffff)) - 20'h80000);
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stalls, compare with the oldest expected result.
    initial out_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        t_res want;
        logic rdy;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (result_queue.size() == 0) begin
                report_mismatch("unexpected transfer", out_ch.r_x, '0);
            end else begin
                want = result_queue.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (out_ch.r_x !== want.r[0] && i == 0) report_mismatch("r_x", out_ch.r_x, want.r[0]);
                    if (out_ch.r_y !== want.r[1] && i == 1) report_mismatch("r_y", out_ch.r_y, want.r[1]);
                    if (out_ch.r_z !== want.r[2] && i == 2) report_mismatch("r_z", out_ch.r_z, want.r[2]);
                    if (out_ch.r_w !== want.r[3] && i == 3) report_mismatch("r_w", out_ch.r_w, want.r[3]);
                end
                if (out_ch.zero_length !== want.zl)
                    report_mismatch("zero_length", 32'(out_ch.zero_length), 32'(want.zl));
            end
        end
        // hold ready low for a long stretch now and then
        if (stall_left > 0) begin
            rdy = 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            case ($urandom_range(0, 63))
                0: begin
                    rdy = 1'b0;
                    stall_left <= int'($urandom_range(20, 100));
                end
                1, 2, 3: rdy = 1'b0;
                default: rdy = ($urandom_range(0, 3) != 0);
            endcase
        end
        if (stim_done && $urandom_range(0, 1)) rdy = 1'b1;
        out_ch.ready <= rdy;
    end

    // Watchdog on cycles with no transfer at all.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_op make_op(t_mode m, logic signed [VW-1:0] a0, a1, a2, a3,
                                    logic signed [VW-1:0] b0, b1, b2, b3);
        t_op op;
        op.mode = m;
        op.a[0] = a0; op.a[1] = a1; op.a[2] = a2; op.a[3] = a3;
        op.b[0] = b0; op.b[1] = b1; op.b[2] = b2; op.b[3] = b3;
        return op;
    endfunction

    task automatic send_op(t_op op, bit has_exp, t_res exp_res);
        t_res want;
        want = has_exp ? exp_res : quat_predict(op);
        in_ch.valid <= 1'b1;
        in_ch.mode  <= op.mode;
        in_ch.a_x <= op.a[0]; in_ch.a_y <= op.a[1]; in_ch.a_z <= op.a[2]; in_ch.a_w <= op.a[3];
        in_ch.b_x <= op.b[0]; in_ch.b_y <= op.b[1]; in_ch.b_z <= op.b[2]; in_ch.b_w <= op.b[3];
        do @(posedge i_clk); while (!in_ch.ready);
        result_queue.push_back(want);
    endtask

    task automatic gap();
        int n;
        case ($urandom_range(0, 19))
            0:       n = $urandom_range(20, 120);
            1, 2, 3: n = $urandom_range(1, 4);
            default: n = 0;
        endcase
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    localparam logic signed [VW-1:0] MAXV = 32'sh7fffffff;
    localparam logic signed [VW-1:0] MINV = 32'sh80000000;
    localparam logic signed [VW-1:0] ONE  = 32'sh00010000;

    t_row rows [$];

    initial begin
        t_row row;
        t_res z;
        t_op  op;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_QMUL;
        in_ch.a_x = '0; in_ch.a_y = '0; in_ch.a_z = '0; in_ch.a_w = '0;
        in_ch.b_x = '0; in_ch.b_y = '0; in_ch.b_z = '0; in_ch.b_w = '0;

        // Directed table: expected results typed in where obvious.
        z.r[0] = '0; z.r[1] = '0; z.r[2] = '0; z.r[3] = '0; z.zl = 1'b1;
        row.has_exp = 1; row.exp_res = z;
        row.op = make_op(MODE_NORM, 0, 0, 0, 0, MAXV, MINV, MAXV, MINV); rows.push_back(row);
        z.zl = 1'b0; row.exp_res = z;
        row.op = make_op(MODE_QMUL, 0, 0, 0, 0, MAXV, MAXV, MINV, MINV); rows.push_back(row);
        row.op = make_op(MODE_VMUL, MAXV, MINV, MAXV, MINV, 0, 0, 0, MAXV); rows.push_back(row);
        z.r[0] = MAXV; z.r[1] = MAXV; z.r[2] = -MAXV; z.r[3] = MINV; row.exp_res = z;
        row.op = make_op(MODE_CONJ, MINV, MINV, MAXV, MINV, 0, 0, 0, 0); rows.push_back(row);
        z.r[0] = '0; z.r[1] = '0; z.r[2] = '0; z.r[3] = ONE; row.exp_res = z;
        row.op = make_op(MODE_QMUL, 0, 0, 0, ONE, 0, 0, 0, ONE); rows.push_back(row);
        row.op = make_op(MODE_NORM, 0, 0, 0, 32'sh00050000, 0, 0, 0, 0); rows.push_back(row);
        row.has_exp = 0;
        row.op = make_op(MODE_QMUL, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV); rows.push_back(row);
        row.op = make_op(MODE_QMUL, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV); rows.push_back(row);
        row.op = make_op(MODE_QMUL, MINV, MAXV, MINV, MAXV, MAXV, MINV, MAXV, MINV); rows.push_back(row);
        row.op = make_op(MODE_VMUL, ONE, 2*ONE, -3*ONE, ONE, ONE, ONE, ONE, MAXV); rows.push_back(row);
        row.op = make_op(MODE_VMUL, MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV, 0); rows.push_back(row);
        row.op = make_op(MODE_QMUL, -1, 1, -1, 1, 1, -1, 1, -1); rows.push_back(row);
        row.op = make_op(MODE_NORM, MAXV, MAXV, MAXV, MAXV, 0, 0, 0, 0); rows.push_back(row);
        row.op = make_op(MODE_NORM, MINV, MINV, MINV, MINV, 0, 0, 0, 0); rows.push_back(row);
        row.op = make_op(MODE_NORM, 1, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.op = make_op(MODE_NORM, -1, 1, -1, 1, 0, 0, 0, 0); rows.push_back(row);
        row.op = make_op(MODE_NORM, MINV, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.op = make_op(MODE_NORM, 3*ONE, -4*ONE, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.op = make_op(MODE_CONJ, 0, 1, -1, MAXV, MINV, 0, 0, 0); rows.push_back(row);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_op(rows[i].op, rows[i].has_exp, rows[i].exp_res);
            gap();
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            op.mode = t_mode'($urandom_range(0, 3));
            for (int k = 0; k < 4; k++) begin
                op.a[k] = rand_val();
                op.b[k] = rand_val();
            end
            if (op.mode == MODE_NORM && $urandom_range(0, 15) == 0)
                for (int k = 0; k < 4; k++) op.a[k] = '0;
            send_op(op, 0, z);
            // Drain the pipeline once midway before going on.
            if (n == N_RANDOM / 2) begin
                in_ch.valid <= 1'b0;
                while (result_queue.size() != 0) @(posedge i_clk);
            end else begin
                gap();
            end
        end
        in_ch.valid <= 1'b0;
        stim_done = 1;

        while (result_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && result_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
